// ===== hdl/dsc_pkg.sv =====
package dsc_pkg;

  localparam int ELAPSED_BITS_DEF = 32;
  localparam int BUTTON_COUNT     = 3;

  localparam int SINCE_W   = 11;
  localparam int DEB_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 4;
  localparam int HALF_W    = 5;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_INT = 2'd2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd20;
  localparam logic [CFG_W-1:0] HOLD_RST     = 11'd400;
  localparam logic [CFG_W-1:0] BEEP_INT_RST = 11'd350;

  // button event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PRESS = 2'd1;
  localparam logic [1:0] EV_HOLD  = 2'd2;

  // watch_mode codes as reported
  localparam logic [1:0] WM_STOPPED = 2'd0;
  localparam logic [1:0] WM_RUNNING = 2'd1;
  localparam logic [1:0] WM_PAUSED  = 2'd2;

  // button lane indexes
  localparam int BTN_UP   = 0;
  localparam int BTN_OK   = 1;
  localparam int BTN_DOWN = 2;

  localparam logic [6:0] MS_IN_TENTH_MAX = 7'd99;
  localparam logic [3:0] TENTHS_MAX      = 4'd9;
  localparam logic [5:0] SEC_MAX         = 6'd59;
  localparam logic [5:0] MIN_MAX         = 6'd59;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'b001,
    MODE_RUNNING = 3'b010,
    MODE_PAUSED  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] beep_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  watch_mode;
    logic [31:0] elapsed_ms;
    logic [10:0] shown_hours;
    logic [5:0]  shown_minutes;
    logic [5:0]  shown_seconds;
    logic [3:0]  shown_tenths;
    logic [1:0]  up_event;
    logic        set_time_request;
    logic        tone_start;
  } result_t;

  function automatic logic [SINCE_W-1:0] sat_inc(input logic [SINCE_W-1:0] v);
    sat_inc = (&v) ? v : v + SINCE_W'(1);
  endfunction

endpackage

// ===== hdl/dsc_button_lane.sv =====
module dsc_button_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                level,
  input  dsc_pkg::cfg_t       cfg,
  output logic [1:0]          event_code
);

  logic                         last_r, last_nxt;
  logic [dsc_pkg::SINCE_W-1:0]  since_r, since_nxt;
  logic                         consumed_r, consumed_nxt;
  logic [dsc_pkg::SINCE_W-1:0]  deb_ext;

  assign deb_ext = dsc_pkg::SINCE_W'(cfg.debounce_ms);

  always_comb begin
    consumed_nxt = consumed_r;
    event_code   = dsc_pkg::EV_NONE;
    since_nxt    = (level != last_r) ? '0 : dsc_pkg::sat_inc(since_r);
    last_nxt     = level;
    if (since_nxt > cfg.hold_ms && !level) begin
      consumed_nxt = 1'b1;
      event_code   = dsc_pkg::EV_HOLD;
    end else if (since_nxt > deb_ext && since_nxt < cfg.hold_ms) begin
      if (!consumed_r && level) begin
        consumed_nxt = 1'b1;
        event_code   = dsc_pkg::EV_PRESS;
      end else if (!level) begin
        // stable low inside the press window arms a press on release
        consumed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r     <= 1'b1;
      since_r    <= '0;
      consumed_r <= 1'b1;
    end else if (step) begin
      last_r     <= last_nxt;
      since_r    <= since_nxt;
      consumed_r <= consumed_nxt;
    end
  end

endmodule

// ===== hdl/dsc_beep_seq.sv =====
module dsc_beep_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [dsc_pkg::REQ_W-1:0]     beep_request,
  input  logic [dsc_pkg::CFG_W-1:0]     beep_interval_ms,
  output logic                          tone_start
);

  logic [dsc_pkg::HALF_W-1:0]  half_r, half_nxt, half_a, half_b;
  logic [dsc_pkg::SINCE_W-1:0] since_r, since_nxt, since_a, since_b;
  logic                        pulse_a, pulse_b;

  always_comb begin
    since_a = dsc_pkg::sat_inc(since_r);
    half_a  = half_r;
    pulse_a = 1'b0;
    // first step on the running sequence
    if (half_a != '0 && since_a > beep_interval_ms) begin
      pulse_a = half_a[0];
      since_a = '0;
      half_a  = half_a - dsc_pkg::HALF_W'(1);
    end
    since_b = since_a;
    half_b  = half_a;
    pulse_b = 1'b0;
    // a new request reloads and gets a second step
    if (beep_request != '0) begin
      half_b = {beep_request, 1'b0} - dsc_pkg::HALF_W'(1);
      if (since_b > beep_interval_ms) begin
        pulse_b = half_b[0];
        since_b = '0;
        half_b  = half_b - dsc_pkg::HALF_W'(1);
      end
    end
    half_nxt   = half_b;
    since_nxt  = since_b;
    tone_start = pulse_a | pulse_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= '0;
      since_r <= '0;
    end else if (step) begin
      half_r  <= half_nxt;
      since_r <= since_nxt;
    end
  end

endmodule

// ===== hdl/dsc_watch_merge.sv =====
module dsc_watch_merge #(
  parameter int ELAPSED_BITS = dsc_pkg::ELAPSED_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        ev_up,
  input  logic [1:0]        ev_ok,
  input  logic [1:0]        ev_down,
  input  logic              tone,
  output dsc_pkg::result_t  result
);

  dsc_pkg::mode_t           mode_r, mode_nxt;
  logic [ELAPSED_BITS-1:0]  elapsed_r, elapsed_nxt;
  logic [6:0]               ms_r, ms_nxt;
  logic [3:0]               tenths_r, tenths_nxt;
  logic [5:0]               sec_r, sec_nxt;
  logic [5:0]               min_r, min_nxt;
  logic [10:0]              hours_r, hours_nxt;
  logic                     counting, clear;
  logic [1:0]               mode_code;

  always_comb begin
    counting    = (mode_r == dsc_pkg::MODE_RUNNING);
    elapsed_nxt = elapsed_r;
    ms_nxt      = ms_r;
    tenths_nxt  = tenths_r;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hours_nxt   = hours_r;

    // mixed-radix digits follow the binary count, so no divider is needed
    if (counting) begin
      elapsed_nxt = elapsed_r + ELAPSED_BITS'(1);
      if (&elapsed_r) begin
        ms_nxt     = '0;
        tenths_nxt = '0;
        sec_nxt    = '0;
        min_nxt    = '0;
        hours_nxt  = '0;
      end else if (ms_r != dsc_pkg::MS_IN_TENTH_MAX) begin
        ms_nxt = ms_r + 7'd1;
      end else begin
        ms_nxt = '0;
        if (tenths_r != dsc_pkg::TENTHS_MAX) begin
          tenths_nxt = tenths_r + 4'd1;
        end else begin
          tenths_nxt = '0;
          if (sec_r != dsc_pkg::SEC_MAX) begin
            sec_nxt = sec_r + 6'd1;
          end else begin
            sec_nxt = '0;
            if (min_r != dsc_pkg::MIN_MAX) begin
              min_nxt = min_r + 6'd1;
            end else begin
              min_nxt   = '0;
              hours_nxt = hours_r + 11'd1;
            end
          end
        end
      end
    end

    mode_nxt = mode_r;
    clear    = 1'b0;
    if (ev_up == dsc_pkg::EV_PRESS) begin
      case (mode_r)
        dsc_pkg::MODE_STOPPED: begin
          mode_nxt = dsc_pkg::MODE_RUNNING;
          clear    = 1'b1;
        end
        dsc_pkg::MODE_RUNNING: mode_nxt = dsc_pkg::MODE_PAUSED;
        default:               mode_nxt = dsc_pkg::MODE_RUNNING;
      endcase
    end
    // down wins over up
    if (ev_down != dsc_pkg::EV_NONE) begin
      mode_nxt = dsc_pkg::MODE_STOPPED;
      clear    = 1'b1;
    end
    if (clear) begin
      elapsed_nxt = '0;
      ms_nxt      = '0;
      tenths_nxt  = '0;
      sec_nxt     = '0;
      min_nxt     = '0;
      hours_nxt   = '0;
    end

    case (mode_nxt)
      dsc_pkg::MODE_STOPPED: mode_code = dsc_pkg::WM_STOPPED;
      dsc_pkg::MODE_RUNNING: mode_code = dsc_pkg::WM_RUNNING;
      dsc_pkg::MODE_PAUSED:  mode_code = dsc_pkg::WM_PAUSED;
      default:               mode_code = dsc_pkg::WM_STOPPED;
    endcase

    result.watch_mode       = mode_code;
    result.elapsed_ms       = 32'(elapsed_nxt);
    result.shown_hours      = hours_nxt;
    result.shown_minutes    = min_nxt;
    result.shown_seconds    = sec_nxt;
    result.shown_tenths     = tenths_nxt;
    result.up_event         = ev_up;
    result.set_time_request = (ev_ok == dsc_pkg::EV_HOLD);
    result.tone_start       = tone;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= dsc_pkg::MODE_STOPPED;
      elapsed_r <= '0;
      ms_r      <= '0;
      tenths_r  <= '0;
      sec_r     <= '0;
      min_r     <= '0;
      hours_r   <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      ms_r      <= ms_nxt;
      tenths_r  <= tenths_nxt;
      sec_r     <= sec_nxt;
      min_r     <= min_nxt;
      hours_r   <= hours_nxt;
    end
  end

endmodule

// ===== hdl/debounced_stopwatch_controller.sv =====
// channel  | direction | handshake           | payload
// in_      | slave     | in_tvalid/tready    | in_tdata: levels and beep request
// out_     | master    | out_tvalid/tready   | out_tdata: mode, time, events, tone
// cfg_     | write     | cfg_wen             | cfg_index, cfg_wdata
//
// one tick per cycle while in_tready is high; each result is registered.
// three debounce lanes and the beep sequencer run in parallel, the watch
// stage merges their events.
// two-entry output buffer: in_tready drops only while both entries are full.
// rst_n synchronous, active low; restores register defaults and clears state.
module debounced_stopwatch_controller #(
  parameter int ELAPSED_BITS = dsc_pkg::ELAPSED_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // up_level, ok_level, down_level, beep_request[3:0], pad
  input  logic [dsc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // watch_mode[1:0], elapsed_ms[31:0], shown_hours[10:0], shown_minutes[5:0],
  // shown_seconds[5:0], shown_tenths[3:0], up_event[1:0], set_time_request,
  // tone_start, pad
  output logic [dsc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_wen,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dsc_pkg::CFG_W-1:0]          cfg_wdata
);

  dsc_pkg::cfg_t     cfg_r;
  dsc_pkg::result_t  res;
  logic              step;
  logic [1:0]        ev [dsc_pkg::BUTTON_COUNT];
  logic              tone;
  logic [dsc_pkg::OUT_TDATA_W-1:0] packed_res;

  logic                            main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  logic [dsc_pkg::OUT_TDATA_W-1:0] main_d_r, main_d_nxt, skid_d_r, skid_d_nxt;
  logic                            pop;

  assign in_tready = !skid_v_r;
  assign step      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= dsc_pkg::DEBOUNCE_RST;
      cfg_r.hold_ms          <= dsc_pkg::HOLD_RST;
      cfg_r.beep_interval_ms <= dsc_pkg::BEEP_INT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dsc_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms <= cfg_wdata[dsc_pkg::DEB_W-1:0];
        dsc_pkg::CFG_HOLD:     cfg_r.hold_ms <= cfg_wdata;
        dsc_pkg::CFG_BEEP_INT: cfg_r.beep_interval_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < dsc_pkg::BUTTON_COUNT; b++) begin : g_lane
    dsc_button_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .level      (in_tdata[b]),
      .cfg        (cfg_r),
      .event_code (ev[b])
    );
  end

  dsc_beep_seq u_beep (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .beep_request     (in_tdata[6:3]),
    .beep_interval_ms (cfg_r.beep_interval_ms),
    .tone_start       (tone)
  );

  dsc_watch_merge #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ev_up   (ev[dsc_pkg::BTN_UP]),
    .ev_ok   (ev[dsc_pkg::BTN_OK]),
    .ev_down (ev[dsc_pkg::BTN_DOWN]),
    .tone    (tone),
    .result  (res)
  );

  assign packed_res = {7'd0, res.tone_start, res.set_time_request, res.up_event,
                       res.shown_tenths, res.shown_seconds, res.shown_minutes,
                       res.shown_hours, res.elapsed_ms, res.watch_mode};

  assign pop = main_v_r && out_tready;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      main_v_nxt = skid_v_r;
      main_d_nxt = skid_d_r;
      skid_v_nxt = 1'b0;
    end
    // skid full blocks step, so a new result never meets a full skid
    if (step) begin
      if (!main_v_nxt) begin
        main_v_nxt = 1'b1;
        main_d_nxt = packed_res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = packed_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = main_v_r;
  assign out_tdata  = main_d_r;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held while output entry empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (step && main_v_r && !out_tready) |=> skid_v_r)
    else $error("transfer during output stall not kept in skid");

  a_stopped_is_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == dsc_pkg::WM_STOPPED) |-> (out_tdata[33:2] == '0))
    else $error("stopped watch reports nonzero time");

  a_no_result_without_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (!main_v_r && !step) |=> !out_tvalid)
    else $error("result appeared without an input transfer");

endmodule
